// ----- sv/edl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edl_pkg
// Shared constants, register indexes and the fractional power-of-two table
// of the exponential damage law evaluator.
// ----------------------------------------------------------------------------
package edl_pkg;

    // pipeline depth from request to result
    localparam int LAT = 37;

    // configuration register indexes
    localparam logic [1:0] REG_THR = 2'd0;
    localparam logic [1:0] REG_RES = 2'd1;
    localparam logic [1:0] REG_SLP = 2'd2;

    // configuration reset values
    localparam logic [39:0] THR_RST = 40'd109951163;
    localparam logic [16:0] RES_RST = 17'd0;
    localparam logic [31:0] SLP_RST = 32'd4096000;

    // fixed point constants
    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [22:0] EXP_ARG_MAX = 23'd4194304;
    localparam logic [32:0] LOG2E_Q32   = 33'd6196328019;
    localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;
    localparam logic [31:0] SLOPE_MAX   = 32'hFFFF_FFFF;

    typedef logic [15:0][31:0] t_hp;

    // bitwise floor square root
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = v;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(-2^i/65536) in Q0.32, built from 2^-0.5 by repeated square roots
    function automatic t_hp build_hp();
        t_hp         hp;
        logic [63:0] s;
        s = isqrt64(64'h8000_0000_0000_0000);
        hp[15] = s[31:0];
        for (int i = 15; i > 0; i--) begin
            s = isqrt64({hp[i], 32'd0});
            hp[i-1] = s[31:0];
        end
        return hp;
    endfunction

    localparam t_hp HALFPOW = build_hp();

endpackage

// ----- sv/edl_exp2.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edl_exp2
// Pipelined 2^(-g/65536) in Q0.32: one table multiply per stage, rounded to
// nearest, over the sixteen bits of g.
// ----------------------------------------------------------------------------
module edl_exp2 (
    input  logic        i_clk,
    input  logic [15:0] i_g,
    output logic [32:0] o_e
);
    import edl_pkg::*;

    logic [32:0] r_e [1:16];
    logic [15:0] r_g [1:15];

    genvar j;
    generate
        for (j = 0; j < 16; j++) begin : g_stg
            logic [32:0] e_in;
            logic [15:0] g_in;
            logic [64:0] prod;
            logic [32:0] n_e;

            // stage input
            if (j == 0) begin : g_first
                assign e_in = ONE_Q32;
                assign g_in = i_g;
            end else begin : g_next
                assign e_in = r_e[j];
                assign g_in = r_g[j];
            end

            // conditional rounded multiply
            assign prod = 65'(e_in) * 65'(HALFPOW[j]) + 65'h8000_0000;
            assign n_e  = g_in[j] ? prod[64:32] : e_in;

            always_ff @(posedge i_clk) begin
                r_e[j+1] <= n_e;
            end

            if (j < 15) begin : g_carry
                always_ff @(posedge i_clk) begin
                    r_g[j+1] <= g_in;
                end
            end
        end
    endgenerate

    assign o_e = r_e[16];

endmodule

// ----- sv/edl_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edl_div
// Pipelined restoring divider: one quotient bit per stage, quotient saturates
// to all ones when it does not fit QW bits.
// ----------------------------------------------------------------------------
module edl_div #(
    parameter int NW = 93,
    parameter int DW = 80,
    parameter int QW = 32
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);
    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [DW-1:0] r_r [0:QW-1];
    logic [DW-1:0] r_d [0:QW-1];
    logic [QW-1:0] r_l [0:QW-1];
    logic [QW-1:0] r_q [0:QW];
    logic          r_s [0:QW];
    logic          w_sat;

    // overflow check and initial partial remainder
    assign w_sat = CW'(i_num) >= (CW'(i_den) << QW);

    always_ff @(posedge i_clk) begin
        r_r[0] <= DW'(i_num >> QW);
        r_d[0] <= i_den;
        r_l[0] <= i_num[QW-1:0];
        r_q[0] <= '0;
        r_s[0] <= w_sat;
    end

    genvar k;
    generate
        for (k = 1; k <= QW; k++) begin : g_bit
            logic [DW:0] t;
            logic [DW:0] dx;
            logic        ge;

            // shift in next numerator bit, compare and subtract
            assign t  = {r_r[k-1], r_l[k-1][QW-k]};
            assign dx = {1'b0, r_d[k-1]};
            assign ge = t >= dx;

            always_ff @(posedge i_clk) begin
                r_q[k] <= {r_q[k-1][QW-2:0], ge};
                r_s[k] <= r_s[k-1];
            end

            // remainder only matters while quotient bits remain
            if (k < QW) begin : g_carry
                always_ff @(posedge i_clk) begin
                    r_r[k] <= ge ? DW'(t - dx) : DW'(t);
                    r_d[k] <= r_d[k-1];
                    r_l[k] <= r_l[k-1];
                end
            end
        end
    endgenerate

    assign o_quo = r_q[QW] | {QW{r_s[QW]}};

endmodule

// ----- sv/exponential_damage_law_eval_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exponential_damage_law_eval_unit
// Exponential softening damage law in fixed point: damage and its slope
// for one history variable kappa per request.
// ----------------------------------------------------------------------------
// pipeline depth from request to result strobe is set by the 32 stage divider
//   for k0(1-A)/kappa^2 behind the kappa squaring stages
// throughput: one request per cycle, busy is low whenever out of reset
// the receiver cannot stall: each result shows for one cycle on o_strobe
// reset: synchronous active low, clears valid bits and loads register defaults
module exponential_damage_law_eval_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [39:0] i_kappa,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [39:0] i_cfg_wdata,
    output logic        o_strobe,
    output logic [16:0] o_damage,
    output logic [31:0] o_damage_slope
);
    import edl_pkg::*;

    typedef struct packed {
        logic       above;
        logic       gt;
        logic       zero;
        logic       fz;
        logic [7:0] n;
    } t_tag;

    // configuration and derived constants
    logic [39:0] r_thr;
    logic [16:0] r_res;
    logic [31:0] r_slp;
    logic [16:0] r_a;
    logic [56:0] r_m;
    logic [48:0] r_p;
    logic [16:0] w_asat;

    // control
    logic           r_live;
    logic           w_acc;
    logic [LAT:1]   r_vld;
    t_tag           r_tag [2:LAT-1];
    t_tag           n_tag [2:LAT-1];

    // stage registers
    logic [39:0] r1_kap;
    logic [39:0] r2_kap;
    logic [51:0] r2_pbh;
    logic [51:0] r2_pbl;
    logic [39:0] r2_hh;
    logic [39:0] r2_hl;
    logic [39:0] r2_ll;
    logic [39:0] r3_kap;
    logic [22:0] r3_y;
    logic [79:0] r3_ksq;
    logic [15:0] r4_f;
    logic [33:0] r21_ex;
    logic [58:0] r22_ppl;
    logic [57:0] r22_pph;
    logic [49:0] r22_ae;
    logic [16:0] r22_q;
    logic [82:0] r23_prod;
    logic [17:0] r23_sq;
    logic [48:0] r_dl [24:LAT-1];
    logic [16:0] r_dmg;
    logic [31:0] r_dsl;

    // combinational
    logic        s1_above;
    logic        s1_gt;
    logic [39:0] s1_diff;
    logic [52:0] s2_ysum;
    logic [36:0] s2_yraw;
    logic [55:0] s3_uprod;
    logic [23:0] s3_u;
    logic [15:0] s4_g;
    logic [32:0] s20_e;
    logic [33:0] s20_ex;
    logic [82:0] s22_prod;
    logic [82:0] s23_sh;
    logic [31:0] s23_t2;
    logic [16:0] s23_d;
    logic [31:0] w_t1;
    logic [16:0] w_q;
    logic [32:0] s36_sum;

    assign busy  = !r_live;
    assign w_acc = start && !busy;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RST;
            r_res <= RES_RST;
            r_slp <= SLP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_THR: r_thr <= i_cfg_wdata;
                REG_RES: r_res <= i_cfg_wdata[16:0];
                REG_SLP: r_slp <= i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // per-configuration products
    assign w_asat = (r_res > ONE_Q16) ? ONE_Q16 : r_res;

    always_ff @(posedge i_clk) begin
        r_a <= w_asat;
        r_m <= 57'(r_thr) * 57'(ONE_Q16 - w_asat);
        r_p <= 49'(w_asat) * 49'(r_slp);
    end

    // valid bits and ready after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
            r_vld  <= '0;
        end else begin
            r_live <= 1'b1;
            r_vld  <= {r_vld[LAT-1:1], w_acc};
        end
    end

    // stage 1: capture request
    always_ff @(posedge i_clk) begin
        r1_kap <= i_kappa;
    end

    // stage 1 -> 2: distance to threshold, exponent and square partials
    assign s1_above = r1_kap >= r_thr;
    assign s1_gt    = r1_kap > r_thr;
    assign s1_diff  = s1_above ? (r1_kap - r_thr) : (r_thr - r1_kap);

    always_ff @(posedge i_clk) begin
        r2_kap <= r1_kap;
        r2_pbh <= 52'(r_slp) * 52'(s1_diff[39:20]);
        r2_pbl <= 52'(r_slp) * 52'(s1_diff[19:0]);
        r2_hh  <= 40'(r1_kap[39:20]) * 40'(r1_kap[39:20]);
        r2_hl  <= 40'(r1_kap[39:20]) * 40'(r1_kap[19:0]);
        r2_ll  <= 40'(r1_kap[19:0]) * 40'(r1_kap[19:0]);
    end

    // stage 2 -> 3: exponent argument with saturation, kappa squared
    assign s2_ysum = 53'(r2_pbh) + 53'(r2_pbl >> 20);
    assign s2_yraw = s2_ysum[52:16];

    always_ff @(posedge i_clk) begin
        r3_kap <= r2_kap;
        r3_y   <= (s2_yraw > 37'(EXP_ARG_MAX)) ? EXP_ARG_MAX : s2_yraw[22:0];
        r3_ksq <= {r2_hh, 40'd0} + {19'd0, r2_hl, 21'd0} + {40'd0, r2_ll};
    end

    // stage 3 -> 4: change to base two
    assign s3_uprod = 56'(r3_y) * 56'(LOG2E_Q32);
    assign s3_u     = s3_uprod[55:32];

    always_ff @(posedge i_clk) begin
        r4_f <= s3_u[15:0];
    end

    // tag pipeline for flags and integer exponent
    always_comb begin
        n_tag[2] = '{above: s1_above, gt: s1_gt, zero: (r1_kap == 40'd0),
                     fz: 1'b0, n: 8'd0};
        for (int k = 3; k < LAT; k++) begin
            n_tag[k] = r_tag[k-1];
        end
        n_tag[4].fz = (s3_u[15:0] == 16'd0);
        n_tag[4].n  = s3_u[23:16];
    end

    always_ff @(posedge i_clk) begin
        for (int k = 2; k < LAT; k++) begin
            r_tag[k] <= n_tag[k];
        end
    end

    // rational damage term m / kappa, 17 quotient bits
    edl_div #(
        .NW (57),
        .DW (40),
        .QW (17)
    ) u_div_dmg (
        .i_clk (i_clk),
        .i_num (r_m),
        .i_den (r3_kap),
        .o_quo (w_q)
    );

    // rational slope term m * 2^36 / kappa^2, 32 quotient bits
    edl_div #(
        .NW (93),
        .DW (80),
        .QW (32)
    ) u_div_slp (
        .i_clk (i_clk),
        .i_num ({r_m, 36'd0}),
        .i_den (r3_ksq),
        .o_quo (w_t1)
    );

    // stages 4 to 20: fractional power of two
    assign s4_g = r_tag[4].above ? r4_f : (16'd0 - r4_f);

    edl_exp2 u_exp2 (
        .i_clk (i_clk),
        .i_g   (s4_g),
        .o_e   (s20_e)
    );

    // stage 20 -> 21: integer exponent applied
    always_comb begin
        if (r_tag[20].above) begin
            s20_ex = (r_tag[20].n > 8'd32) ? 34'd0 : 34'(s20_e >> r_tag[20].n);
        end else begin
            s20_ex = r_tag[20].fz ? 34'(ONE_Q32) : {s20_e, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r21_ex <= s20_ex;
    end

    // stage 21 -> 22: partial products of A*B*exp and A*exp
    always_ff @(posedge i_clk) begin
        r22_ppl <= 59'(r_p[24:0]) * 59'(r21_ex);
        r22_pph <= 58'(r_p[48:25]) * 58'(r21_ex);
        r22_ae  <= 50'(r_a) * 50'(r21_ex[32:0]);
        r22_q   <= w_q;
    end

    // stage 22 -> 23: sum partials and damage subtrahend
    assign s22_prod = {r22_pph, 25'd0} + 83'(r22_ppl);

    always_ff @(posedge i_clk) begin
        r23_prod <= s22_prod;
        r23_sq   <= 18'(r22_q) + r22_ae[49:32];
    end

    // stage 23 -> 24: exponential slope term and damage
    always_comb begin
        s23_sh = '0;
        if (r_tag[23].above) begin
            s23_sh = r23_prod >> 48;
            s23_t2 = (s23_sh[82:32] != '0) ? SLOPE_MAX : s23_sh[31:0];
        end else if (r_p == '0) begin
            s23_t2 = 32'd0;
        end else if (r_tag[23].n >= 8'd48) begin
            s23_t2 = SLOPE_MAX;
        end else begin
            s23_sh = r23_prod >> (6'd48 - r_tag[23].n[5:0]);
            s23_t2 = (s23_sh[82:32] != '0) ? SLOPE_MAX : s23_sh[31:0];
        end

        if (r_tag[23].gt && r23_sq < 18'(ONE_Q16)) begin
            s23_d = ONE_Q16 - r23_sq[16:0];
        end else begin
            s23_d = 17'd0;
        end
    end

    // stages 24 to 36: hold until the slope divider finishes
    always_ff @(posedge i_clk) begin
        r_dl[24] <= {s23_d, s23_t2};
        for (int k = 25; k < LAT; k++) begin
            r_dl[k] <= r_dl[k-1];
        end
    end

    // stage 36 -> 37: saturating slope sum and zero kappa case
    assign s36_sum = 33'(w_t1) + 33'(r_dl[LAT-1][31:0]);

    always_ff @(posedge i_clk) begin
        if (r_tag[LAT-1].zero) begin
            r_dmg <= 17'd0;
            r_dsl <= SLOPE_MAX;
        end else begin
            r_dmg <= r_dl[LAT-1][48:32];
            r_dsl <= s36_sum[32] ? SLOPE_MAX : s36_sum[31:0];
        end
    end

    assign o_strobe       = r_vld[LAT];
    assign o_damage       = r_dmg;
    assign o_damage_slope = r_dsl;

    // every request yields exactly one result after the fixed latency
    a_lat_fwd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##LAT o_strobe)
        else $error("result missing after request");

    a_lat_bwd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_acc, LAT))
        else $error("result without request");

    // zero kappa gives zero damage and a saturated slope
    a_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && $past(i_kappa == 40'd0, LAT) |->
            (o_damage == 17'd0) && (o_damage_slope == SLOPE_MAX))
        else $error("zero kappa result wrong");

    // damage never exceeds one
    a_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_damage <= ONE_Q16)
        else $error("damage out of range");

endmodule

// ----- verif/exponential_damage_law_eval_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exponential_damage_law_eval_unit_tb
// Self-checking bench for the exponential damage law evaluator. Requests of
// kappa go in with random gaps. A fixed point damage model predicts damage
// and slope for each accepted request, and every strobed result is compared
// in order with those predictions, under several register settings.
// ----------------------------------------------------------------------------
module exponential_damage_law_eval_unit_tb;
    import edl_pkg::*;

    typedef struct packed {
        logic [16:0] damage;
        logic [31:0] slope;
    } t_damage_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [39:0] i_kappa;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [39:0] i_cfg_wdata;
    logic        o_strobe;
    logic [16:0] o_damage;
    logic [31:0] o_damage_slope;

    // model copy of the registers
    logic [39:0] thr_q;
    logic [16:0] res_q;
    logic [31:0] slp_q;
    logic [31:0] root_tab [16];

    t_damage_out pending_out[$];
    int          err_cnt;
    int          req_cnt;
    int          res_cnt;
    int          cfg_cnt;
    int          cyc_cnt;

    exponential_damage_law_eval_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kappa        (i_kappa),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_strobe       (o_strobe),
        .o_damage       (o_damage),
        .o_damage_slope (o_damage_slope)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt > 300000) begin
            $display("timeout after %0d cycles", cyc_cnt);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // floor square root
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = v;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(-g/65536) in Q0.32
    function automatic logic [63:0] pow2_frac(input logic [15:0] g);
        logic [63:0] f;
        f = 64'd1 << 32;
        for (int i = 0; i < 16; i++)
            if (g[i]) f = (f * root_tab[i] + (64'd1 << 31)) >> 32;
        return f;
    endfunction

    function automatic logic [31:0] sat32(input logic [127:0] v);
        return (v > 128'hFFFF_FFFF) ? SLOPE_MAX : v[31:0];
    endfunction

    // damage and slope for one kappa under the current registers
    function automatic t_damage_out predict_damage(input logic [39:0] kappa);
        t_damage_out  r;
        logic [63:0]  a;
        logic [63:0]  diff;
        logic [63:0]  y;
        logic [63:0]  u;
        logic [63:0]  n;
        logic [63:0]  f;
        logic [63:0]  m;
        logic [63:0]  p;
        logic [63:0]  e;
        logic [63:0]  g;
        logic [63:0]  s;
        logic [127:0] t1;
        logic [127:0] t2;
        logic [127:0] sq;
        logic         above;
        r = '0;
        if (kappa == 0) begin
            r.slope = SLOPE_MAX;
            return r;
        end
        a = (res_q > ONE_Q16) ? 64'(ONE_Q16) : 64'(res_q);
        above = kappa >= thr_q;
        diff = above ? 64'(kappa - thr_q) : 64'(thr_q - kappa);
        y = (64'(slp_q) * (diff >> 20) + ((64'(slp_q) * (diff & 64'hFFFFF)) >> 20)) >> 16;
        if (y > EXP_ARG_MAX) y = EXP_ARG_MAX;
        u = (y * 64'(LOG2E_Q32)) >> 32;
        n = u >> 16;
        f = u & 64'hFFFF;
        m = 64'(thr_q) * (64'(ONE_Q16) - a);
        p = a * 64'(slp_q);
        sq = 128'(kappa) * 128'(kappa);
        t1 = (128'(m) << 36) / sq;
        if (above) begin
            e = (n > 32) ? 64'd0 : (pow2_frac(f[15:0]) >> n);
            t2 = (128'(p) * 128'(e)) >> 48;
            if (kappa > thr_q) begin
                s = m / 64'(kappa) + ((a * e) >> 32);
                r.damage = (s >= ONE_Q16) ? 17'd0 : 17'(64'(ONE_Q16) - s);
            end
        end else begin
            g = (f == 0) ? (64'd1 << 32) : (pow2_frac(16'(64'(ONE_Q16) - f)) << 1);
            if (p == 0) t2 = 0;
            else if (n >= 48) t2 = 128'hFFFF_FFFF;
            else t2 = (128'(p) * 128'(g)) >> (48 - n);
        end
        r.slope = sat32(128'(sat32(t1)) + 128'(sat32(t2)));
        return r;
    endfunction

    task automatic report_err(input string what, input logic [63:0] got,
                              input logic [63:0] want);
        err_cnt++;
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                 res_cnt);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_damage_out want;
        if (i_rst_n && o_strobe) begin
            if (pending_out.size() == 0) begin
                report_err("unexpected result", 64'(o_damage), 64'd0);
            end else begin
                want = pending_out.pop_front();
                if (o_damage !== want.damage)
                    report_err("damage", 64'(o_damage), 64'(want.damage));
                if (o_damage_slope !== want.slope)
                    report_err("damage_slope", 64'(o_damage_slope), 64'(want.slope));
            end
            res_cnt++;
        end
    end

    task automatic idle_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // send one request, record its prediction once accepted
    task automatic send_kappa(input logic [39:0] kappa, input bit gaps);
        start   <= 1'b1;
        i_kappa <= kappa;
        do @(posedge i_clk); while (busy);
        pending_out.push_back(predict_damage(kappa));
        req_cnt++;
        if (gaps) idle_gap();
    endtask

    // register write, only once everything has drained
    task automatic write_reg(input logic [1:0] idx, input logic [39:0] val);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_out.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_THR: thr_q = val;
            REG_RES: res_q = val[16:0];
            REG_SLP: slp_q = val[31:0];
            default: ;
        endcase
        cfg_cnt++;
    endtask

    function automatic logic [39:0] rand_kappa();
        int          mode;
        logic [39:0] k;
        mode = $urandom_range(0, 9);
        case (mode)
            0, 1, 2: k = {8'($urandom), 32'($urandom)};
            3, 4, 5: k = thr_q + 40'($urandom_range(0, 1 << $urandom_range(0, 30)));
            6, 7:    k = thr_q - 40'($urandom_range(0, 1 << $urandom_range(0, 30)));
            8:       k = 40'($urandom_range(0, 1000));
            default: k = {8'($urandom), 32'($urandom)} >> $urandom_range(0, 39);
        endcase
        return k;
    endfunction

    task automatic test_defaults();
        send_kappa(40'd0, 0);
        send_kappa(40'd1, 0);
        send_kappa(thr_q - 1, 0);
        send_kappa(thr_q, 0);
        send_kappa(thr_q + 1, 0);
        send_kappa(thr_q * 2, 1);
        send_kappa(40'hFF_FFFF_FFFF, 1);
        send_kappa(40'hAA_AAAA_AAAA, 1);
        send_kappa(40'h55_5555_5555, 1);
    endtask

    task automatic test_register_extremes();
        // residual above one saturates, zero slope, max slope
        write_reg(REG_RES, 40'h1_FFFF);
        write_reg(REG_SLP, 40'hFFFF_FFFF);
        send_kappa(thr_q + 1000, 1);
        send_kappa(thr_q - 1, 1);
        send_kappa(40'd1, 1);
        write_reg(REG_RES, 40'd65536);
        write_reg(REG_SLP, 40'd0);
        send_kappa(thr_q + 5, 1);
        send_kappa(thr_q - 5, 1);
        // threshold zero and threshold one
        write_reg(REG_THR, 40'd0);
        write_reg(REG_RES, 40'd32768);
        write_reg(REG_SLP, 40'd4096000);
        send_kappa(40'd1, 1);
        send_kappa(40'hFF_FFFF_FFFF, 1);
        write_reg(REG_THR, 40'd1);
        send_kappa(40'd1, 1);
        send_kappa(40'd2, 1);
        // threshold at maximum, growth far below it
        write_reg(REG_THR, 40'hFF_FFFF_FFFF);
        write_reg(REG_SLP, 40'hFFFF_FFFF);
        send_kappa(40'd1, 1);
        send_kappa(40'hFF_FFFF_FFFF, 1);
        send_kappa(40'h80_0000_0000, 1);
    endtask

    task automatic test_random_phases();
        int          sel;
        logic [39:0] v;
        for (int ph = 0; ph < 13; ph++) begin
            sel = $urandom_range(0, 3);
            v = (sel == 0) ? 40'($urandom_range(1, 1000)) :
                (sel == 1) ? {8'($urandom), 32'($urandom)} :
                40'($urandom_range(1, 32'h7FFF_FFFF)) >> $urandom_range(0, 16);
            write_reg(REG_THR, v);
            sel = $urandom_range(0, 3);
            v = (sel == 0) ? 40'd0 : (sel == 1) ? 40'd65536 :
                40'($urandom_range(0, 131071));
            write_reg(REG_RES, v);
            sel = $urandom_range(0, 2);
            v = (sel == 0) ? 40'($urandom) :
                40'($urandom) >> $urandom_range(0, 31);
            write_reg(REG_SLP, v);
            for (int k = 0; k < 48; k++) send_kappa(rand_kappa(), 1);
        end
    endtask

    initial begin
        start       <= 1'b0;
        i_kappa     <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= REG_THR;
        i_cfg_wdata <= '0;
        i_rst_n     <= 1'b0;
        cyc_cnt = 0;
        err_cnt = 0;
        req_cnt = 0;
        res_cnt = 0;
        cfg_cnt = 0;
        thr_q = THR_RST;
        res_q = RES_RST;
        slp_q = SLP_RST;
        // own table of 2^(-2^i/65536) from repeated square roots of 2^-0.5
        root_tab[15] = 32'(floor_sqrt(64'd1 << 63));
        for (int i = 15; i > 0; i--) root_tab[i-1] = 32'(floor_sqrt({root_tab[i], 32'd0}));
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_register_extremes();
        test_random_phases();

        start <= 1'b0;
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
        $display("covered %0d requests, %0d results, %0d register writes", req_cnt,
                 res_cnt, cfg_cnt);
        $display("mismatches: %0d", err_cnt);
        if (err_cnt == 0 && res_cnt == req_cnt) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
